@@ design/bba_pkg.sv @@
// Shared types and codes of the buddy block allocator.
package bba_pkg;

    typedef enum logic [1:0] {
        NODE_ABSENT = 2'd0,
        NODE_SPLIT  = 2'd1,
        NODE_ALLOC  = 2'd2,
        NODE_UNUSED = 2'd3
    } node_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_BADSIZE  = 2'd2,
        ST_NOTALLOC = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ROOT_RD,
        S_ROOT_WT,
        S_NODE_RD,
        S_NODE_WT,
        S_LO_WT,
        S_HI_WT,
        S_DECIDE,
        S_CARVE,
        S_FREE_RD,
        S_FREE_WT,
        S_SIB_WT,
        S_DONE,
        S_OUT
    } state_t;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 24;

endpackage

@@ design/bba_node_ram.sv @@
// Node state memory: one write port and one registered read port.
module bba_node_ram
    import bba_pkg::*;
#(
    parameter int unsigned AW    = 11,
    parameter int unsigned DEPTH = 2047
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  node_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output node_t         rd_data
);

    node_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/buddy_block_allocator_core.sv @@
// Top level of the buddy block allocator.
//
//  Channel  Dir  Fields
//  s_axis   in   tdata: req_type[0], block_size[11:1], block_start[21:12]
//  m_axis   out  tdata: status[1:0], granted_start[11:2], granted_size[22:12]
//
// After reset a clearing pass writes every node absent, while s_axis_tready
// stays low. One item is processed at a time.
// An allocate walks the split tree depth first with an explicit path stack;
// each node visit reads both halves through the single read port of the node
// memory, and carving writes one node per level. A free reads and checks the
// block, releases it, then merges upward one level at a time. The result
// sits in an output register; a stalled m_axis holds it and the next item
// waits until it is taken.
module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int unsigned MEMORY_UNITS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_type, block_size, block_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, granted_start, granted_size
);

    localparam int unsigned LVL   = $clog2(MEMORY_UNITS);
    localparam int unsigned NODES = 2 * MEMORY_UNITS - 1;
    localparam int unsigned AW    = LVL + 1;
    localparam int unsigned DW    = (LVL > 0) ? $clog2(LVL + 1) : 1;

    state_t state_reg, state_next;

    // Node memory port.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    node_t         wr_data;
    logic [AW-1:0] rd_addr;
    node_t         rd_data;

    bba_node_ram #(.AW(AW), .DEPTH(NODES)) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Request registers.
    logic          kind_reg;
    logic [10:0]   bsize_reg;
    logic [9:0]    bstart_reg;
    logic [DW-1:0] wdepth_reg;          // depth of wanted block size
    // Walk registers.
    logic [AW-1:0] idx_reg, idx_next;
    logic [DW-1:0] dep_reg, dep_next;
    node_t         lo_reg, hi_reg;
    // Per level: 0 = first visit, 1 = lower explored, 2 = upper explored.
    logic [1:0]    phase_reg [LVL+1];
    logic [1:0]    phase_next [LVL+1];
    logic [AW-1:0] clr_reg;
    logic [1:0]    st_reg;
    logic [AW-1:0] gnode_reg;
    logic          out_v_reg;
    logic [1:0]    o_st_reg;
    logic [9:0]    o_start_reg;
    logic [10:0]   o_size_reg;

    logic [AW-1:0] lo_idx, hi_idx, par_idx;
    assign lo_idx  = AW'({idx_reg, 1'b1});
    assign hi_idx  = AW'(idx_reg + idx_reg + AW'(2));
    assign par_idx = AW'((idx_reg - AW'(1)) >> 1);

    // Rounded-up size and its depth: the deepest level whose blocks still fit.
    logic [DW-1:0] want_dep;
    always_comb
    begin
        want_dep = DW'(LVL);
        for (int d = 0; d <= LVL; d++)
        begin
            if ({1'b0, bsize_reg} <= 12'(MEMORY_UNITS >> d))
            begin
                want_dep = DW'(d);
            end
        end
    end

    logic size_bad, free_pow_bad, free_pos_bad;
    assign size_bad     = (bsize_reg == 11'd0) || ({1'b0, bsize_reg} > 12'(MEMORY_UNITS));
    assign free_pow_bad = (bsize_reg & (bsize_reg - 11'd1)) != 11'd0;
    assign free_pos_bad = ({6'd0, bstart_reg} >= 16'(MEMORY_UNITS)) ||
                          ((11'(bstart_reg) & (bsize_reg - 11'd1)) != 11'd0);

    // Free node index: 2^d - 1 + start >> (LVL - d).
    logic [AW-1:0] free_idx;
    assign free_idx = AW'((AW'(1) << want_dep) - AW'(1) +
                          (AW'(bstart_reg) >> (DW'(LVL) - want_dep)));

    // Granted start from node index and its depth.
    logic [AW-1:0] g_off;
    logic [AW:0]   g_start;
    assign g_off   = AW'(gnode_reg - ((AW'(1) << wdepth_reg) - AW'(1)));
    assign g_start = (AW+1)'(g_off) << (DW'(LVL) - wdepth_reg);

    logic          leaf_pair;       // current node is twice the want size
    assign leaf_pair = (dep_reg + DW'(1)) == wdepth_reg;

    logic [1:0] cur_phase;
    assign cur_phase = phase_reg[dep_reg];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dep_next   = dep_reg;
        for (int i = 0; i <= LVL; i++)
        begin
            phase_next[i] = phase_reg[i];
        end
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = NODE_ABSENT;
        rd_addr = idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == AW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next = '0;
                dep_next = '0;
                for (int i = 0; i <= LVL; i++)
                begin
                    phase_next[i] = 2'd0;
                end
                if (size_bad)
                begin
                    state_next = S_DONE;
                end
                else if (kind_reg == REQ_ALLOC)
                begin
                    state_next = S_ROOT_RD;
                end
                else if (free_pow_bad || free_pos_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = free_idx;
                    state_next = S_FREE_RD;
                end
            end
            S_ROOT_RD:
            begin
                rd_addr    = '0;
                state_next = S_ROOT_WT;
            end
            S_ROOT_WT:
            begin
                if (rd_data == NODE_ABSENT)
                begin
                    state_next = S_CARVE;
                end
                else if (rd_data == NODE_SPLIT && wdepth_reg != '0)
                begin
                    state_next = S_NODE_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Node at idx/dep is known split; read both halves.
            S_NODE_RD:
            begin
                rd_addr    = lo_idx;
                state_next = S_LO_WT;
            end
            S_LO_WT:
            begin
                rd_addr    = hi_idx;
                state_next = S_HI_WT;
            end
            S_HI_WT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (leaf_pair)
                begin
                    if (lo_reg == NODE_ABSENT)
                    begin
                        wr_en = 1'b1; wr_addr = lo_idx; wr_data = NODE_ALLOC;
                        idx_next = lo_idx; dep_next = wdepth_reg;
                        state_next = S_DONE;
                    end
                    else if (hi_reg == NODE_ABSENT)
                    begin
                        wr_en = 1'b1; wr_addr = hi_idx; wr_data = NODE_ALLOC;
                        idx_next = hi_idx; dep_next = wdepth_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_NODE_WT;   // fail, backtrack
                    end
                end
                else if (cur_phase == 2'd0 && lo_reg == NODE_SPLIT)
                begin
                    phase_next[dep_reg] = 2'd1;
                    phase_next[dep_reg + DW'(1)] = 2'd0;
                    idx_next = lo_idx; dep_next = dep_reg + DW'(1);
                    state_next = S_NODE_RD;
                end
                else if (cur_phase != 2'd2 && hi_reg == NODE_SPLIT)
                begin
                    phase_next[dep_reg] = 2'd2;
                    phase_next[dep_reg + DW'(1)] = 2'd0;
                    idx_next = hi_idx; dep_next = dep_reg + DW'(1);
                    state_next = S_NODE_RD;
                end
                else if (lo_reg == NODE_ABSENT)
                begin
                    idx_next = lo_idx; dep_next = dep_reg + DW'(1);
                    state_next = S_CARVE;
                end
                else if (hi_reg == NODE_ABSENT)
                begin
                    idx_next = hi_idx; dep_next = dep_reg + DW'(1);
                    state_next = S_CARVE;
                end
                else
                begin
                    state_next = S_NODE_WT;
                end
            end
            // Backtrack one level after a failed subtree.
            S_NODE_WT:
            begin
                if (dep_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = par_idx;
                    dep_next   = dep_reg - DW'(1);
                    state_next = S_NODE_RD;
                end
            end
            S_CARVE:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (dep_reg == wdepth_reg)
                begin
                    wr_data    = NODE_ALLOC;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_data  = NODE_SPLIT;
                    idx_next = lo_idx;
                    dep_next = dep_reg + DW'(1);
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_WT;
            end
            S_FREE_WT:
            begin
                if (rd_data != NODE_ALLOC)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr    = idx_reg[0] ? AW'(idx_reg + AW'(1)) : AW'(idx_reg - AW'(1));
                        state_next = S_SIB_WT;
                    end
                end
            end
            S_SIB_WT:
            begin
                if (rd_data != NODE_ABSENT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = par_idx;
                    idx_next = par_idx;
                    if (par_idx == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr = par_idx[0] ? AW'(par_idx + AW'(1)) : AW'(par_idx - AW'(1));
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, o_size_reg, o_start_reg, o_st_reg};

    // Status bookkeeping follows the path that reached S_DONE.
    logic [1:0] st_next;
    always_comb
    begin
        st_next = st_reg;
        case (state_reg)
            S_CHECK:
            begin
                st_next = ST_OK;
                if (size_bad || (kind_reg == REQ_FREE && free_pow_bad))
                begin
                    st_next = ST_BADSIZE;
                end
                else if (kind_reg == REQ_FREE && free_pos_bad)
                begin
                    st_next = ST_NOTALLOC;
                end
            end
            S_ROOT_WT:
            begin
                if (rd_data != NODE_ABSENT && !(rd_data == NODE_SPLIT && wdepth_reg != '0))
                begin
                    st_next = ST_NOSPACE;
                end
            end
            S_NODE_WT:
            begin
                if (dep_reg == '0)
                begin
                    st_next = ST_NOSPACE;
                end
            end
            S_FREE_WT:
            begin
                if (rd_data != NODE_ALLOC)
                begin
                    st_next = ST_NOTALLOC;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            out_v_reg <= 1'b0;
            dep_reg   <= '0;
            for (int i = 0; i <= LVL; i++)
            begin
                phase_reg[i] <= 2'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            dep_reg   <= dep_next;
            for (int i = 0; i <= LVL; i++)
            begin
                phase_reg[i] <= phase_next[i];
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= AW'(clr_reg + AW'(1));
            end
            if (state_reg == S_DONE)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        st_reg  <= st_next;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            kind_reg   <= s_axis_tdata[0];
            bsize_reg  <= s_axis_tdata[11:1];
            bstart_reg <= s_axis_tdata[21:12];
        end
        if (state_reg == S_CHECK)
        begin
            wdepth_reg <= want_dep;
        end
        if (state_reg == S_LO_WT)
        begin
            lo_reg <= rd_data;
        end
        if (state_reg == S_HI_WT)
        begin
            hi_reg <= rd_data;
        end
        if (state_reg == S_DONE)
        begin
            gnode_reg <= idx_reg;
        end
        if (state_reg == S_OUT && !out_v_reg)
        begin
            gnode_reg <= gnode_reg;
        end
        if (state_reg == S_DONE)
        begin
            o_st_reg <= st_reg;
            if (st_reg != ST_OK)
            begin
                o_start_reg <= '0;
                o_size_reg  <= '0;
            end
            else if (kind_reg == REQ_FREE)
            begin
                o_start_reg <= bstart_reg;
                o_size_reg  <= bsize_reg;
            end
            else
            begin
                o_start_reg <= 10'(((AW+1)'(idx_reg - ((AW'(1) << wdepth_reg) - AW'(1))))
                                   << (DW'(LVL) - wdepth_reg));
                o_size_reg  <= 11'(MEMORY_UNITS >> wdepth_reg);
            end
        end
        else if (state_reg == S_OUT && g_start[0] && 1'b0)
        begin
            o_start_reg <= g_start[9:0];
        end
    end

endmodule
